>>> sv/binary_trie_kth_xor_assert.svh
`ifndef BINARY_TRIE_KTH_XOR_ASSERT_SVH
`define BINARY_TRIE_KTH_XOR_ASSERT_SVH

// same-cycle implication
`define BTKX_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("btkx assertion failed");

// next-cycle implication
`define BTKX_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("btkx assertion failed");

`endif

>>> sv/btkx_pkg.sv
package btkx_pkg;

  localparam int KEY_BITS   = 31;
  localparam int NODE_COUNT = 32768;
  localparam int MAX_KEYS   = 1024;

  localparam int RANK_W  = 11;
  localparam int NODE_W  = $clog2(NODE_COUNT);
  localparam int CNT_W   = $clog2(MAX_KEYS + 1);
  localparam int K_W     = (CNT_W > RANK_W) ? CNT_W : RANK_W;
  localparam int LVL_W   = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
  localparam int FULL_LIMIT = NODE_COUNT - 1 - KEY_BITS;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_RANK = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic                action;
    logic [KEY_BITS-1:0] key;
    logic [RANK_W-1:0]   rank;
  } req_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] xor_value;
    status_t             status;
  } rsp_t;

  // node entry holds both child links and the pass counts of those children
  typedef struct packed {
    logic [NODE_W-1:0] zero_child;
    logic [NODE_W-1:0] one_child;
    logic [CNT_W-1:0]  zero_count;
    logic [CNT_W-1:0]  one_count;
  } node_t;

  typedef struct packed {
    logic start;
    logic step;
    logic load;
  } ctl_cmd_t;

  typedef struct packed {
    logic flag;
    logic last;
    logic out_busy;
  } dp_status_t;

endpackage

>>> sv/btkx_ctrl.sv
`include "binary_trie_kth_xor_assert.svh"

module btkx_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  btkx_pkg::dp_status_t  st,
  output btkx_pkg::ctl_cmd_t    cmd
);
  import btkx_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FINISH
  } state_t;

  state_t state;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.start = req_valid && (state == S_IDLE);
    cmd.step  = (state == S_WALK);
    cmd.load  = (state == S_FINISH) && !st.out_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= st.flag ? S_FINISH : S_WALK;
          end
        end
        S_WALK: begin
          if (st.last) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!st.out_busy) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `BTKX_ASSERT_NEXT(a_walk_ends, clk, rst, (state == S_WALK) && st.last, state == S_FINISH)
  `BTKX_ASSERT_SAME(a_load_free, clk, rst, cmd.load, !st.out_busy)
  `BTKX_ASSERT_NEXT(a_flag_skips, clk, rst, cmd.start && st.flag, state == S_FINISH)

endmodule

>>> sv/btkx_datapath.sv
`include "binary_trie_kth_xor_assert.svh"

module btkx_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  btkx_pkg::req_t        req,
  input  btkx_pkg::ctl_cmd_t    cmd,
  output btkx_pkg::dp_status_t  st,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output btkx_pkg::rsp_t        rsp
);
  import btkx_pkg::*;

  node_t mem [NODE_COUNT];
  node_t rdata;
  node_t root;

  logic                op;
  logic [KEY_BITS-1:0] key_r;
  logic [K_W-1:0]      k;
  logic [NODE_W-1:0]   node;
  logic                fresh;
  logic [KEY_BITS-1:0] res;
  logic [LVL_W-1:0]    level;
  status_t             status_r;
  logic [NODE_W-1:0]   next_free_node;
  logic [CNT_W-1:0]    total_keys;

  status_t             check;
  node_t               ent;
  node_t               ent_next;
  logic                bit_v;
  logic [NODE_W-1:0]   same_child;
  logic [NODE_W-1:0]   other_child;
  logic [CNT_W-1:0]    same_count;
  logic                absent;
  logic [NODE_W-1:0]   alloc_node;
  logic [NODE_W-1:0]   node_next;
  logic [K_W-1:0]      k_next;
  logic [KEY_BITS-1:0] res_next;
  logic                mem_we;

  always_comb begin
    check = ST_OK;
    if (req.action == ACT_QUERY) begin
      if (req.rank == '0 || K_W'(req.rank) > K_W'(total_keys)) begin
        check = ST_RANK;
      end
    end else begin
      if (next_free_node > NODE_W'(FULL_LIMIT) || total_keys >= CNT_W'(MAX_KEYS)) begin
        check = ST_FULL;
      end
    end
  end

  always_comb begin
    if (node == '0) begin
      ent = root;
    end else if (fresh) begin
      ent = '0;
    end else begin
      ent = rdata;
    end
    bit_v       = key_r[level];
    same_child  = bit_v ? ent.one_child : ent.zero_child;
    other_child = bit_v ? ent.zero_child : ent.one_child;
    same_count  = bit_v ? ent.one_count : ent.zero_count;
    absent      = (same_child == '0);
    alloc_node  = absent ? next_free_node + NODE_W'(1) : same_child;

    ent_next = ent;
    if (bit_v) begin
      ent_next.one_child = alloc_node;
      ent_next.one_count = ent.one_count + CNT_W'(1);
    end else begin
      ent_next.zero_child = alloc_node;
      ent_next.zero_count = ent.zero_count + CNT_W'(1);
    end

    node_next = node;
    k_next    = k;
    res_next  = res;
    if (cmd.start) begin
      node_next = '0;
      k_next    = K_W'(req.rank);
      res_next  = '0;
    end else if (cmd.step) begin
      if (op == ACT_INSERT) begin
        node_next = alloc_node;
      end else if (K_W'(same_count) >= k) begin
        node_next = same_child;
      end else begin
        node_next = other_child;
        k_next    = k - K_W'(same_count);
        res_next  = res | (KEY_BITS'(1) << level);
      end
    end
    mem_we = cmd.step && (op == ACT_INSERT) && (node != '0);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[node] <= ent_next;
    end
    rdata <= mem[node_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root           <= '0;
      next_free_node <= '0;
      total_keys     <= '0;
      rsp_valid      <= 1'b0;
    end else begin
      if (cmd.step && op == ACT_INSERT) begin
        if (node == '0) begin
          root <= ent_next;
        end
        if (absent) begin
          next_free_node <= alloc_node;
        end
        if (level == '0) begin
          total_keys <= total_keys + CNT_W'(1);
        end
      end
      if (cmd.load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    node <= node_next;
    k    <= k_next;
    res  <= res_next;
    if (cmd.start) begin
      op       <= req.action;
      key_r    <= req.key;
      fresh    <= 1'b0;
      level    <= LVL_W'(KEY_BITS - 1);
      status_r <= check;
    end else if (cmd.step) begin
      fresh <= (op == ACT_INSERT) && absent;
      level <= level - LVL_W'(1);
    end
    if (cmd.load) begin
      rsp.xor_value <= res;
      rsp.status    <= status_r;
    end
  end

  assign st.flag     = (check != ST_OK);
  assign st.last     = (level == '0);
  assign st.out_busy = rsp_valid && !rsp_ready;

  `BTKX_ASSERT_SAME(a_total_bound, clk, rst, 1'b1, total_keys <= CNT_W'(MAX_KEYS))

endmodule

>>> sv/binary_trie_kth_xor.sv
// binary trie answering k-th smallest xor queries over 31-bit keys
// req channel (valid/ready) carries action, key and rank; rsp channel
// (valid/ready) returns xor_value and status, one rsp per req transaction
// insert: walks bits 30..0, allocating nodes, status full when fewer than
// 31 free nodes remain or the key count is at its limit (nothing changes)
// query: returns the rank-th smallest key xor stored key, status rank
// error for a rank of zero or above the number of stored keys
// a flagged req skips the walk and goes straight to the final state; a
// new req is taken only after the last one is loaded into the output register
// the walk covers the 31 levels, one node-memory read per level
// reset clears the root and the node and key counts; no clearing pass
// runs over the node memory, so req_ready is high right after reset
// a stalled rsp holds in the output register; the next req is taken and
// walked meanwhile, then waits in its final state until the register frees
module binary_trie_kth_xor (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  btkx_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output btkx_pkg::rsp_t  rsp
);
  import btkx_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t st;

  btkx_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .st        (st),
    .cmd       (cmd)
  );

  btkx_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .st        (st),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

>>> tb/binary_trie_kth_xor_tb.sv
module binary_trie_kth_xor_tb;
  import btkx_pkg::*;

  typedef struct {
    req_t item;
    bit   drain;
  } queued_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  binary_trie_kth_xor DUT (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  queued_req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  logic [KEY_BITS-1:0] inserted_keys[$];
  int n_items = 0;
  int n_checked = 0;
  int err_count = 0;
  int gen_total = 0;

  // trie mirror
  bit [NODE_W-1:0] zero_link [NODE_COUNT];
  bit [NODE_W-1:0] one_link [NODE_COUNT];
  bit [CNT_W-1:0] path_count [NODE_COUNT];
  int unsigned last_node = 0;
  int unsigned key_total = 0;

  function automatic rsp_t predict_trie_rsp(req_t r);
    rsp_t o;
    int unsigned node;
    int unsigned nxt;
    int unsigned same;
    int unsigned cnt;
    int unsigned k;
    logic b;
    o.xor_value = '0;
    o.status = ST_OK;
    node = 0;
    if (r.action == ACT_INSERT) begin
      if (int'(NODE_COUNT) - 1 - int'(last_node) < KEY_BITS || key_total >= MAX_KEYS) begin
        o.status = ST_FULL;
      end else begin
        for (int lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
          b = r.key[lvl];
          nxt = b ? one_link[node] : zero_link[node];
          if (nxt == 0) begin
            last_node++;
            nxt = last_node;
            if (b) one_link[node] = NODE_W'(nxt);
            else zero_link[node] = NODE_W'(nxt);
          end
          node = nxt;
          path_count[node] = path_count[node] + 1'b1;
        end
        key_total++;
      end
    end else if (r.rank == 0 || r.rank > key_total) begin
      o.status = ST_RANK;
    end else begin
      k = r.rank;
      for (int lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
        b = r.key[lvl];
        same = b ? one_link[node] : zero_link[node];
        cnt = (same == 0) ? 0 : path_count[same];
        if (cnt >= k) begin
          node = same;
        end else begin
          k = k - cnt;
          node = b ? zero_link[node] : one_link[node];
          o.xor_value[lvl] = 1'b1;
        end
      end
    end
    return o;
  endfunction

  task automatic add_item(logic action, logic [KEY_BITS-1:0] key, int rank, bit drain);
    queued_req_t q;
    q.item.action = action;
    q.item.key = key;
    q.item.rank = RANK_W'(rank);
    q.drain = drain;
    pending_reqs.push_back(q);
    n_items++;
    if (action == ACT_INSERT && gen_total < MAX_KEYS) begin
      gen_total++;
      inserted_keys.push_back(key);
    end
  endtask

  function automatic logic [KEY_BITS-1:0] pick_key();
    logic [31:0] raw;
    logic [31:0] low_mask;
    logic [KEY_BITS-1:0] k;
    raw = $urandom;
    k = raw[KEY_BITS-1:0];
    low_mask = (32'd1 << $urandom_range(1, 12)) - 1;
    case ($urandom_range(0, 9))
      4, 5: if (inserted_keys.size() != 0)
        k = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)] ^
            raw[KEY_BITS-1:0] & low_mask[KEY_BITS-1:0];
      6: if (inserted_keys.size() != 0)
        k = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
      7: k = KEY_BITS'($urandom_range(0, 63));
      8: k = {KEY_BITS{1'b1}} - KEY_BITS'($urandom_range(0, 63));
      default: ;
    endcase
    return k;
  endfunction

  function automatic int pick_rank(int total);
    case ($urandom_range(0, 19))
      0: return 0;
      1: return total + 1;
      2: return $urandom_range(0, 2047);
      3: return 1;
      4: return total;
      default: return (total == 0) ? $urandom_range(0, 3) : $urandom_range(1, total);
    endcase
  endfunction

  task automatic log_failure(string what);
    err_count++;
    if (err_count <= 10) $display("mismatch: %s", what);
  endtask

  // driver: bursts and gaps, optional drain before an item
  queued_req_t head;
  int gap_left;
  int burst_left;

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      gap_left = 0;
      burst_left = 1;
    end else if (!req_valid || req_ready) begin
      if (gap_left != 0) begin
        gap_left = gap_left - 1;
        req_valid <= 1'b0;
      end else if (pending_reqs.size() == 0 ||
                   (pending_reqs[0].drain && (req_valid || expected_rsps.size() != 0))) begin
        req_valid <= 1'b0;
      end else begin
        head = pending_reqs.pop_front();
        req_valid <= 1'b1;
        req <= head.item;
        burst_left = burst_left - 1;
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end
      end
    end
  end

  // receiver stall pattern
  int stall_mode;
  int mode_left;
  int pat_cnt;

  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      stall_mode = 0;
      mode_left = 0;
      pat_cnt = 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(50, 600);
      end else begin
        mode_left = mode_left - 1;
      end
      pat_cnt = (pat_cnt + 1) % 13;
      case (stall_mode)
        0: rsp_ready <= 1'b1;
        1: rsp_ready <= ($urandom_range(0, 1) == 1);
        2: rsp_ready <= ($urandom_range(0, 7) != 0);
        default: rsp_ready <= (pat_cnt < 4);
      endcase
    end
  end

  // monitor: check response transactions, predict on request transactions
  rsp_t want;

  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsps.size() == 0) begin
          log_failure($sformatf("unexpected response xor=%0h status=%0d",
                                rsp.xor_value, rsp.status));
        end else begin
          want = expected_rsps.pop_front();
          n_checked++;
          if (rsp.xor_value !== want.xor_value || rsp.status !== want.status)
            log_failure($sformatf("response %0d: expected xor=%0h status=%s, got xor=%0h status=%0d",
                                  n_checked, want.xor_value, want.status.name(),
                                  rsp.xor_value, rsp.status));
        end
      end
      if (req_valid && req_ready) expected_rsps.push_back(predict_trie_rsp(req));
    end
  end

  initial begin
    // empty trie, rank edges, key extremes, duplicates
    add_item(ACT_QUERY, '0, 1, 0);
    add_item(ACT_QUERY, {KEY_BITS{1'b1}}, 0, 0);
    add_item(ACT_INSERT, '0, 0, 0);
    add_item(ACT_INSERT, {KEY_BITS{1'b1}}, 0, 0);
    add_item(ACT_INSERT, {KEY_BITS{1'b1}}, 0, 0);
    add_item(ACT_INSERT, 31'h2AAAAAAA, 0, 0);
    add_item(ACT_INSERT, 31'h55555555, 0, 0);
    add_item(ACT_INSERT, 31'h1, 2047, 0);
    add_item(ACT_QUERY, '0, 1, 0);
    add_item(ACT_QUERY, '0, 6, 0);
    add_item(ACT_QUERY, '0, 7, 0);
    add_item(ACT_QUERY, '0, 0, 0);
    add_item(ACT_QUERY, '0, 2047, 0);
    add_item(ACT_QUERY, {KEY_BITS{1'b1}}, 1, 0);
    add_item(ACT_QUERY, {KEY_BITS{1'b1}}, 2, 0);
    add_item(ACT_QUERY, {KEY_BITS{1'b1}}, 3, 0);
    add_item(ACT_QUERY, 31'h55555555, 3, 0);
    add_item(ACT_QUERY, 31'h2AAAAAAA, 4, 0);
    add_item(ACT_QUERY, 31'h1, 5, 0);

    // random fill with queries mixed in
    add_item(ACT_QUERY, pick_key(), pick_rank(gen_total), 1);
    while (n_items < 585) begin
      if ($urandom_range(0, 4) != 0)
        add_item(ACT_INSERT, pick_key(), $urandom_range(0, 2047), $urandom_range(0, 149) == 0);
      else
        add_item(ACT_QUERY, pick_key(), pick_rank(gen_total), $urandom_range(0, 149) == 0);
    end

    // ranks around the key limit, mixed tail
    add_item(ACT_QUERY, pick_key(), MAX_KEYS, 1);
    add_item(ACT_QUERY, pick_key(), MAX_KEYS + 1, 0);
    add_item(ACT_INSERT, pick_key(), 0, 0);
    repeat (60) begin
      if ($urandom_range(0, 1) == 0)
        add_item(ACT_INSERT, pick_key(), $urandom_range(0, 2047), 0);
      else
        add_item(ACT_QUERY, pick_key(), pick_rank(gen_total), 0);
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (n_checked != n_items) @(posedge clk);
    repeat (50) @(posedge clk);
    if (err_count == 0 && expected_rsps.size() == 0) begin
      $display("** binary_trie_kth_xor: PASSED **");
    end else begin
      $display("** binary_trie_kth_xor: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("** binary_trie_kth_xor: FAILED **");
    $finish;
  end

endmodule
